// File: rtl/core/multichannel_led_triangle_fader_top_assert.svh
// Assertion macros used by the triangle fader RTL
`ifndef MULTICHANNEL_LED_TRIANGLE_FADER_TOP_ASSERT_SVH
`define MULTICHANNEL_LED_TRIANGLE_FADER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define LTF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define LTF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ltf_pkg.sv
// Types and constants of the triangle fader
package ltf_pkg;

  localparam int CH_FIELD_W   = 4;
  localparam int DUTY_FIELD_W = 13;
  localparam int TICKS_W      = 16;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_CFG  = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [CH_FIELD_W-1:0]   channel;
    logic [DUTY_FIELD_W-1:0] peak_duty;
    logic [TICKS_W-1:0]      fade_ticks;
  } in_item_t;

  typedef struct packed {
    logic [CH_FIELD_W-1:0]   out_channel;
    logic [DUTY_FIELD_W-1:0] duty;
    logic                    falling;
    logic                    turned;
  } out_item_t;

endpackage

// File: rtl/core/multichannel_led_triangle_fader_top.sv
// An accepted item goes through execute, then a divide phase for a reversal tick or a
// configure item, where the bit-serial divider forms a bit a cycle, then write-back, which
// also loads a tick's result into the output register; no new item is taken before that.
// Configure gives no result, and a stalled output register holds the next tick back.
// Synchronous active-low reset clears the channel table's valid bits, so every
// channel reads as duty 0, peak 0, step 0, rising, fade time 1 straight away.
module multichannel_led_triangle_fader_top import ltf_pkg::*; #(
  parameter int CHANNELS  = 16,
  parameter int DUTY_BITS = 13
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  `include "multichannel_led_triangle_fader_top_assert.svh"

  localparam int DW = DUTY_BITS;
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]         st_r, st_nxt;
  logic               kind_r;
  logic [CW-1:0]      ch_r;
  logic [DW-1:0]      peak_in_r;
  logic [TICKS_W-1:0] ticks_in_r;
  logic [DW-1:0]      duty_r, step_r, peak_r;
  logic               down_r, turned_r;
  logic [TICKS_W-1:0] time_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r;

  logic               accept, in_range;
  logic [DW-1:0]      row_duty, row_step, row_peak;
  logic               row_down;
  logic [TICKS_W-1:0] row_time;
  logic [DW:0]        sum_up;
  logic [DW-1:0]      nd, dclamp;
  logic               turn;
  logic               div_start, div_done;
  logic [DW-1:0]      div_dividend, div_q;
  logic [TICKS_W-1:0] div_divisor;
  logic               out_free, wr_en, out_load;

  assign accept   = in_valid && !in_stall;
  assign in_range = 32'(in_data.channel) < CHANNELS;
  assign in_stall = st_r != ST_IDLE;

  ltf_chan_mem #(
    .CHANNELS (CHANNELS),
    .DW       (DW),
    .CW       (CW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept && in_range),
    .rd_addr (CW'(in_data.channel)),
    .wr_en   (wr_en),
    .wr_addr (ch_r),
    .wr_duty (duty_r),
    .wr_step (step_r),
    .wr_down (down_r),
    .wr_peak (peak_r),
    .wr_time (time_r),
    .rd_duty (row_duty),
    .rd_step (row_step),
    .rd_down (row_down),
    .rd_peak (row_peak),
    .rd_time (row_time)
  );

  // step magnitude always follows the direction, so no sign is stored
  always_comb begin
    sum_up = {1'b0, row_duty} + {1'b0, row_step};
    if (!row_down) begin
      nd   = (sum_up > {1'b0, row_peak}) ? row_peak : sum_up[DW-1:0];
      turn = nd == row_peak;
    end else begin
      nd   = (row_duty > row_step) ? row_duty - row_step : '0;
      turn = nd == '0;
    end
    dclamp = (row_duty > peak_in_r) ? peak_in_r : row_duty;
  end

  // on either reversal the span to cover is the whole peak
  assign div_start    = (st_r == ST_EXEC) && (kind_r == KIND_CFG || turn);
  assign div_dividend = (kind_r == KIND_CFG) ? peak_in_r - dclamp : row_peak;
  assign div_divisor  = (kind_r == KIND_CFG) ? ticks_in_r : row_time;

  ltf_div #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (st_r == ST_DONE) && (kind_r == KIND_TICK) && out_free;
  assign wr_en    = (st_r == ST_DONE) && (kind_r == KIND_CFG || out_free);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (accept && in_range) begin
          st_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        st_nxt = div_start ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (div_done) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (wr_en) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r     <= in_data.kind;
      ch_r       <= CW'(in_data.channel);
      peak_in_r  <= DW'(in_data.peak_duty);
      ticks_in_r <= (in_data.fade_ticks == '0) ? TICKS_W'(1) : in_data.fade_ticks;
    end
    if (st_r == ST_EXEC) begin
      if (kind_r == KIND_CFG) begin
        duty_r   <= dclamp;
        peak_r   <= peak_in_r;
        time_r   <= ticks_in_r;
        down_r   <= 1'b0;
        turned_r <= 1'b0;
      end else begin
        duty_r   <= nd;
        peak_r   <= row_peak;
        time_r   <= row_time;
        down_r   <= row_down ^ turn;
        turned_r <= turn;
      end
      step_r <= row_step;
    end
    if (st_r == ST_DIV && div_done) begin
      // a step that divides out to nothing still moves by one
      step_r <= (div_q == '0) ? DW'(1) : div_q;
    end
    if (out_load) begin
      out_data_r.out_channel <= CH_FIELD_W'(ch_r);
      out_data_r.duty        <= DUTY_FIELD_W'(duty_r);
      out_data_r.falling     <= down_r;
      out_data_r.turned      <= turned_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LTF_ASSERT_NOW(a_duty_in_range, clk, rst_n, st_r == ST_DONE, duty_r <= peak_r,
                  "duty above peak at write-back")
  `LTF_ASSERT_NOW(a_step_nonzero, clk, rst_n, st_r == ST_DONE, step_r != '0,
                  "zero step written back")
  `LTF_ASSERT_NOW(a_div_done_in_div, clk, rst_n, div_done, st_r == ST_DIV,
                  "divider finished outside the divide phase")
  `LTF_ASSERT_NEXT(a_accept_reads, clk, rst_n, accept && in_range, st_r == ST_EXEC,
                   "accepted item did not enter execute")

endmodule

// File: rtl/core/ltf_div.sv
// Bit-serial restoring divider: one quotient bit per cycle
module ltf_div import ltf_pkg::*; #(
  parameter int DW = 13
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DW-1:0]      dividend,
  input  logic [TICKS_W-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic               busy_r, busy_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DW-1:0]      num_r, num_nxt;
  logic [TICKS_W-1:0] rem_r, rem_nxt;
  logic [TICKS_W-1:0] dsr_r, dsr_nxt;
  logic [TICKS_W:0]   trial;
  logic               ge;

  assign trial    = {rem_r, num_r[DW-1]};
  assign ge       = trial >= {1'b0, dsr_r};
  assign done     = busy_r && (cnt_r == '0);
  assign quotient = num_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DW);
      num_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        // shift the next dividend bit into the remainder, the quotient bit in at the bottom
        num_nxt = {num_r[DW-2:0], ge};
        rem_nxt = ge ? TICKS_W'(trial - {1'b0, dsr_r}) : trial[TICKS_W-1:0];
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule

// File: rtl/core/ltf_chan_mem.sv
// Per-channel fader state table with valid bits
module ltf_chan_mem import ltf_pkg::*; #(
  parameter int CHANNELS = 16,
  parameter int DW       = 13,
  parameter int CW       = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [CW-1:0]      rd_addr,
  input  logic               wr_en,
  input  logic [CW-1:0]      wr_addr,
  input  logic [DW-1:0]      wr_duty,
  input  logic [DW-1:0]      wr_step,
  input  logic               wr_down,
  input  logic [DW-1:0]      wr_peak,
  input  logic [TICKS_W-1:0] wr_time,
  output logic [DW-1:0]      rd_duty,
  output logic [DW-1:0]      rd_step,
  output logic               rd_down,
  output logic [DW-1:0]      rd_peak,
  output logic [TICKS_W-1:0] rd_time
);

  localparam int ROW_W = 3 * DW + 1 + TICKS_W;
  localparam logic [ROW_W-1:0] RESET_ROW = {{(3 * DW + 1){1'b0}}, TICKS_W'(1)};

  logic [ROW_W-1:0]    mem [CHANNELS];
  logic [CHANNELS-1:0] vld_r;
  logic [ROW_W-1:0]    rd_q_r;
  logic                hit_r;
  logic [ROW_W-1:0]    row;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_duty, wr_step, wr_down, wr_peak, wr_time};
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_r <= vld_r[rd_addr];
      end
    end
  end

  // an unwritten channel reads as its reset state
  assign row = hit_r ? rd_q_r : RESET_ROW;
  assign {rd_duty, rd_step, rd_down, rd_peak, rd_time} = row;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the multichannel triangle fader: directed table, then random items
`timescale 1ns / 100ps

module testbench;
  import ltf_pkg::*;

  localparam int NCH        = 16;
  localparam int DUTY_W     = DUTY_FIELD_W;
  localparam int CYCLE_CAP  = 400000;
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN_WAIT = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  multichannel_led_triangle_fader_top #(
    .CHANNELS (NCH),
    .DUTY_BITS(DUTY_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // Per-channel fader state as the block should hold it
  logic [DUTY_W-1:0]        lvl_duty [NCH];
  logic [DUTY_W-1:0]        lvl_goal [NCH];
  logic [DUTY_W-1:0]        lvl_peak [NCH];
  logic signed [DUTY_W:0]   lvl_step [NCH];
  bit                       lvl_down [NCH];
  logic [TICKS_W-1:0]       lvl_time [NCH];

  out_item_t pending_duties[$];
  bit        failed = 1'b0;
  int        mism_cnt = 0;
  int        cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_req = 0;
  int        hold_seen = 0;
  int        hold_left = 0;

  typedef struct packed {
    logic               kind;
    logic [3:0]         ch;
    logic [DUTY_W-1:0]  peak;
    logic [TICKS_W-1:0] ticks;
    bit                 typed;
    logic [DUTY_W-1:0]  w_duty;
    bit                 w_fall;
    bit                 w_turn;
  } fade_row_t;

  fade_row_t fade_plan[$];

  function automatic int fade_step(int goal, int from, int ticks, bit down);
    int s;
    s = (goal - from) / ticks;
    if (down) begin
      if (s > -1) s = -1;
    end else if (s < 1) begin
      s = 1;
    end
    return s;
  endfunction

  function automatic bit advance_fader(input in_item_t it, output out_item_t res);
    int c;
    int nd;
    int tk;
    bit turn;
    res = '0;
    c = int'(it.channel);
    // drop items for channels the block does not have
    if (c >= NCH) return 1'b0;
    if (it.kind == KIND_CFG) begin
      tk = (it.fade_ticks == 0) ? 1 : int'(it.fade_ticks);
      lvl_peak[c] = it.peak_duty;
      lvl_time[c] = TICKS_W'(tk);
      if (lvl_duty[c] > it.peak_duty) lvl_duty[c] = it.peak_duty;
      lvl_down[c] = 1'b0;
      lvl_goal[c] = it.peak_duty;
      lvl_step[c] = (DUTY_W+1)'(fade_step(int'(it.peak_duty), int'(lvl_duty[c]), tk, 1'b0));
      return 1'b0;
    end
    nd = int'(lvl_duty[c]) + int'(lvl_step[c]);
    if (nd < 0) nd = 0;
    if (nd > int'(lvl_peak[c])) nd = int'(lvl_peak[c]);
    lvl_duty[c] = DUTY_W'(nd);
    turn = (!lvl_down[c] && nd >= int'(lvl_goal[c])) || (lvl_down[c] && nd <= 0);
    if (turn) begin
      lvl_down[c] = !lvl_down[c];
      lvl_goal[c] = lvl_down[c] ? '0 : lvl_peak[c];
      lvl_step[c] = (DUTY_W+1)'(fade_step(int'(lvl_goal[c]), nd, int'(lvl_time[c]),
                                          lvl_down[c]));
    end
    res.out_channel = CH_FIELD_W'(c);
    res.duty        = DUTY_FIELD_W'(nd);
    res.falling     = lvl_down[c];
    res.turned      = turn;
    return 1'b1;
  endfunction

  task automatic add_row(logic kind, int ch, int peak, int ticks,
                         bit typed, int w_duty, bit w_fall, bit w_turn);
    fade_row_t r;
    r.kind   = kind;
    r.ch     = 4'(ch);
    r.peak   = DUTY_W'(peak);
    r.ticks  = TICKS_W'(ticks);
    r.typed  = typed;
    r.w_duty = DUTY_W'(w_duty);
    r.w_fall = w_fall;
    r.w_turn = w_turn;
    fade_plan.push_back(r);
  endtask

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (advance_fader(it, res)) pending_duties.push_back(typed ? typed_res : res);
  endtask

  // Receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_duties.size() == 0) begin
        failed = 1'b1;
        if (mism_cnt < 30)
          $display("%0t: unexpected item: expected none, ", $time,
                   "actual ch=%0d duty=%0d falling=%0b turned=%0b",
                   out_data.out_channel, out_data.duty, out_data.falling,
                   out_data.turned);
        mism_cnt++;
      end else begin
        want = pending_duties.pop_front();
        if (out_data.out_channel !== want.out_channel || out_data.duty !== want.duty ||
            out_data.falling !== want.falling || out_data.turned !== want.turned) begin
          failed = 1'b1;
          if (mism_cnt < 30)
            $display("%0t: mismatch: expected ch=%0d duty=%0d falling=%0b turned=%0b, ",
                     $time, want.out_channel, want.duty, want.falling, want.turned,
                     "actual ch=%0d duty=%0d falling=%0b turned=%0b",
                     out_data.out_channel, out_data.duty, out_data.falling, out_data.turned);
          mism_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    in_item_t  it;
    out_item_t typed_res;
    int        r;

    for (int c = 0; c < NCH; c++) begin
      lvl_duty[c] = '0;
      lvl_goal[c] = '0;
      lvl_peak[c] = '0;
      lvl_step[c] = '0;
      lvl_down[c] = 1'b0;
      lvl_time[c] = TICKS_W'(1);
    end

    // Zero peak after reset: turns on every tick
    add_row(KIND_TICK, 0, 0, 0, 1, 0, 1, 1);
    add_row(KIND_TICK, 0, 0, 0, 1, 0, 0, 1);
    // Full peak, zero fade time: one tick per half
    add_row(KIND_CFG, 15, 8191, 0, 0, 0, 0, 0);
    add_row(KIND_TICK, 15, 8191, 65535, 1, 8191, 1, 1);
    add_row(KIND_TICK, 15, 0, 0, 1, 0, 0, 1);
    // Longest fade: step rounds to zero and is forced to one
    add_row(KIND_CFG, 3, 8191, 65535, 0, 0, 0, 0);
    add_row(KIND_TICK, 3, 0, 0, 0, 0, 0, 0);
    add_row(KIND_TICK, 3, 0, 0, 0, 0, 0, 0);
    add_row(KIND_CFG, 5, 100, 1, 0, 0, 0, 0);
    add_row(KIND_TICK, 5, 0, 0, 1, 100, 1, 1);
    // Lower the peak below the duty: clamp on configure
    add_row(KIND_CFG, 5, 40, 3, 0, 0, 0, 0);
    add_row(KIND_TICK, 5, 0, 0, 0, 0, 0, 0);
    add_row(KIND_TICK, 5, 0, 0, 0, 0, 0, 0);
    add_row(KIND_TICK, 5, 0, 0, 0, 0, 0, 0);
    add_row(KIND_CFG, 10, 'h1555, 'hAAAA, 0, 0, 0, 0);
    add_row(KIND_TICK, 10, 'h0AAA, 'h5555, 0, 0, 0, 0);
    add_row(KIND_CFG, 10, 'h0AAA, 'h5555, 0, 0, 0, 0);
    add_row(KIND_TICK, 10, 0, 0, 0, 0, 0, 0);
    add_row(KIND_CFG, 7, 7, 2, 0, 0, 0, 0);
    add_row(KIND_TICK, 7, 0, 0, 0, 0, 0, 0);
    add_row(KIND_TICK, 7, 0, 0, 0, 0, 0, 0);
    add_row(KIND_TICK, 7, 0, 0, 0, 0, 0, 0);
    add_row(KIND_TICK, 7, 0, 0, 0, 0, 0, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (fade_plan[i]) begin
      it.kind       = fade_plan[i].kind;
      it.channel    = fade_plan[i].ch;
      it.peak_duty  = fade_plan[i].peak;
      it.fade_ticks = fade_plan[i].ticks;
      typed_res.out_channel = fade_plan[i].ch;
      typed_res.duty        = fade_plan[i].w_duty;
      typed_res.falling     = fade_plan[i].w_fall;
      typed_res.turned      = fade_plan[i].w_turn;
      send_item(it, fade_plan[i].typed, typed_res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int n = 0; n < 105; n++) begin
        r = $urandom_range(99);
        it.kind       = KIND_TICK;
        it.channel    = CH_FIELD_W'($urandom_range(3));
        it.peak_duty  = DUTY_FIELD_W'($urandom);
        it.fade_ticks = TICKS_W'($urandom);
        if (r < 12) begin
          it.kind = KIND_CFG;
          if ($urandom_range(1)) it.channel = CH_FIELD_W'($urandom);
          case ($urandom_range(9))
            0: it.peak_duty = '0;
            1: it.peak_duty = '1;
            2, 3, 4, 5: it.peak_duty = DUTY_FIELD_W'($urandom_range(1, 64));
            default: it.peak_duty = DUTY_FIELD_W'($urandom);
          endcase
          case ($urandom_range(9))
            0: it.fade_ticks = '0;
            1: it.fade_ticks = '1;
            2: it.fade_ticks = TICKS_W'($urandom);
            default: it.fade_ticks = TICKS_W'($urandom_range(1, 6));
          endcase
        end else if (r < 30) begin
          it.channel = CH_FIELD_W'($urandom);
        end
        send_item(it, 1'b0, typed_res);
      end

      if (ph == 1) begin
        // Hold the receiver off and offer 24 ticks, so the input stalls behind the held output
        send_idle_pct = 0;
        hold_req++;
        for (int n = 0; n < 24; n++) begin
          it.kind       = KIND_TICK;
          it.channel    = CH_FIELD_W'($urandom);
          it.peak_duty  = DUTY_FIELD_W'($urandom);
          it.fade_ticks = TICKS_W'($urandom);
          send_item(it, 1'b0, typed_res);
        end
        // Pause until every outstanding result has come back
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_duties.size() != 0);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_duties.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (!failed)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

// File: multichannel_led_triangle_fader_top.f
+incdir+rtl/core
rtl/core/ltf_pkg.sv
rtl/core/ltf_div.sv
rtl/core/ltf_chan_mem.sv
rtl/core/multichannel_led_triangle_fader_top.sv
tb/testbench.sv
